// File: rtl/core/bfha_pkg.sv
// Shared types and constants of the best-fit heap allocator.
package bfha_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int BLOCK_HDR_DEF  = 16;
    localparam int POOL_HDR_DEF   = 4;

    localparam int SIZE_ALIGN = 4;
    localparam int SPLIT_MIN  = 16;
    localparam int POOL_MIN   = 64;
    localparam int POOL_MAX   = 65536;

    localparam logic [16:0] ADDR_MAX = 17'h0FFFF;

    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_BADOFF = 2'd2;

    typedef struct packed {
        logic        valid;
        logic        used;
        logic [15:0] start;
        logic [16:0] pay;
    } t_entry;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_INIT  = 3'd1,
        CMD_WR    = 3'd2,
        CMD_SPLIT = 3'd3,
        CMD_MERGE = 3'd4
    } t_cmd_op;

    // Table edit broadcast to every cell; a goes to the addressed cell, b to its successor
    typedef struct packed {
        t_cmd_op op;
        t_entry  a;
        t_entry  b;
    } t_cmd;

    typedef struct packed {
        logic [16:0] size;
        logic [15:0] offset;
    } t_query;

    // Scan packet passed cell to cell: best fit so far and the offset hit
    typedef struct packed {
        logic        b_found;
        logic [16:0] b_pay;
        logic [15:0] b_start;
        logic        h_found;
        logic        h_used;
        logic [15:0] h_start;
        logic [16:0] h_pay;
        logic        p_ok;
        logic [15:0] p_start;
        logic [16:0] p_pay;
        logic        n_ok;
        logic [16:0] n_pay;
    } t_scan;

endpackage

// File: rtl/core/best_fit_heap_allocator_top.sv
// Best-fit heap allocator: block table held in a chain of cells plus its sequencer.
//
// The block table lives in a row of MAX_BLOCKS cells, one entry each, in address
// order. A request is answered by a scan packet that ripples through the chain,
// one cell per cycle; the table edits that follow (split, merge, entry removal)
// are shifts across all cells, at most two per scan and three for a resize to
// zero bytes, which frees and then rescans. A finished result that finds the
// output register still full waits there. Items are taken one at a time; the
// finished result sits in an output register, so a new item is accepted while it
// waits. Writing the pool size (i_cfg_we, i_cfg_data) re-initializes the table;
// the user must write it only when idle, as the block itself does not enforce this.
module best_fit_heap_allocator_top #(
    parameter int MAX_BLOCKS = bfha_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_HDR  = bfha_pkg::BLOCK_HDR_DEF,
    parameter int POOL_HDR   = bfha_pkg::POOL_HDR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_result_offset,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data
);
    import bfha_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);

    t_cmd             w_cmd;
    logic [IDX_W-1:0] w_cmd_idx;
    t_query           w_query;
    t_entry           w_entry [MAX_BLOCKS];
    t_entry           w_left  [MAX_BLOCKS];
    t_entry           w_right [MAX_BLOCKS];
    t_scan            w_scan  [MAX_BLOCKS+1];
    logic [IDX_W-1:0] w_b_idx [MAX_BLOCKS+1];
    logic [IDX_W-1:0] w_h_idx [MAX_BLOCKS+1];

    assign w_scan[0]  = '0;
    assign w_b_idx[0] = '0;
    assign w_h_idx[0] = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_mid_l
            assign w_left[g] = w_entry[g-1];
        end
        if (g == MAX_BLOCKS - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_mid_r
            assign w_right[g] = w_entry[g+1];
        end

        bfha_cell #(
            .MAX_BLOCKS (MAX_BLOCKS),
            .BLOCK_HDR  (BLOCK_HDR),
            .POOL_HDR   (POOL_HDR),
            .IDX        (g),
            .IDX_W      (IDX_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_cmd_idx (w_cmd_idx),
            .i_left    (w_left[g]),
            .i_right   (w_right[g]),
            .i_query   (w_query),
            .i_scan    (w_scan[g]),
            .i_b_idx   (w_b_idx[g]),
            .i_h_idx   (w_h_idx[g]),
            .o_entry   (w_entry[g]),
            .o_scan    (w_scan[g+1]),
            .o_b_idx   (w_b_idx[g+1]),
            .o_h_idx   (w_h_idx[g+1])
        );
    end

    bfha_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .BLOCK_HDR  (BLOCK_HDR),
        .POOL_HDR   (POOL_HDR),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_req_size      (i_req_size),
        .i_offset        (i_offset),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_result_offset (o_result_offset),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_cmd           (w_cmd),
        .o_cmd_idx       (w_cmd_idx),
        .o_query         (w_query),
        .i_scan          (w_scan[MAX_BLOCKS]),
        .i_b_idx         (w_b_idx[MAX_BLOCKS]),
        .i_h_idx         (w_h_idx[MAX_BLOCKS])
    );

endmodule

// File: rtl/core/bfha_cell.sv
// One table cell: holds one block entry, applies edits and forwards the scan packet.
module bfha_cell #(
    parameter int MAX_BLOCKS = bfha_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_HDR  = bfha_pkg::BLOCK_HDR_DEF,
    parameter int POOL_HDR   = bfha_pkg::POOL_HDR_DEF,
    parameter int IDX        = 0,
    parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfha_pkg::t_cmd     i_cmd,
    input  logic [IDX_W-1:0]   i_cmd_idx,
    input  bfha_pkg::t_entry   i_left,
    input  bfha_pkg::t_entry   i_right,
    input  bfha_pkg::t_query   i_query,
    input  bfha_pkg::t_scan    i_scan,
    input  logic [IDX_W-1:0]   i_b_idx,
    input  logic [IDX_W-1:0]   i_h_idx,
    output bfha_pkg::t_entry   o_entry,
    output bfha_pkg::t_scan    o_scan,
    output logic [IDX_W-1:0]   o_b_idx,
    output logic [IDX_W-1:0]   o_h_idx
);
    import bfha_pkg::*;

    localparam logic [16:0]    HDR = 17'(BLOCK_HDR);
    localparam logic [IDX_W:0] ME  = (IDX_W+1)'(IDX);
    localparam t_entry RST_ENTRY = '{valid: 1'b1, used: 1'b0, start: 16'(POOL_HDR),
                                     pay: 17'(POOL_MAX - POOL_HDR - BLOCK_HDR)};

    t_entry           r_entry, n_entry;
    t_scan            r_scan, n_scan;
    logic [IDX_W-1:0] r_b_idx, n_b_idx, r_h_idx, n_h_idx;
    logic [IDX_W:0]   k, k1;
    logic [16:0]      hdr_end;
    logic             fit;

    assign k       = {1'b0, i_cmd_idx};
    assign k1      = k + 1'b1;
    assign hdr_end = {1'b0, r_entry.start} + HDR;
    assign fit     = r_entry.valid && !r_entry.used && (r_entry.pay >= i_query.size)
                     && (hdr_end <= ADDR_MAX);

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            CMD_NONE:  ;
            CMD_INIT:  n_entry = (IDX == 0) ? i_cmd.a : '0;
            CMD_WR:    if (ME == k) n_entry = i_cmd.a;
            CMD_SPLIT: begin
                if (ME == k)       n_entry = i_cmd.a;
                else if (ME == k1) n_entry = i_cmd.b;
                else if (ME > k1)  n_entry = i_left;
            end
            CMD_MERGE: begin
                if (ME == k)      n_entry = i_cmd.a;
                else if (ME > k)  n_entry = i_right;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_scan  = i_scan;
        n_b_idx = i_b_idx;
        n_h_idx = i_h_idx;
        // strict compare keeps the lowest address on ties
        if (fit && (!i_scan.b_found || r_entry.pay < i_scan.b_pay)) begin
            n_scan.b_found = 1'b1;
            n_scan.b_pay   = r_entry.pay;
            n_scan.b_start = r_entry.start;
            n_b_idx        = IDX_W'(IDX);
        end
        if (!i_scan.h_found && r_entry.valid && hdr_end == {1'b0, i_query.offset}) begin
            n_scan.h_found = 1'b1;
            n_scan.h_used  = r_entry.used;
            n_scan.h_start = r_entry.start;
            n_scan.h_pay   = r_entry.pay;
            n_scan.p_ok    = i_left.valid && !i_left.used;
            n_scan.p_start = i_left.start;
            n_scan.p_pay   = i_left.pay;
            n_scan.n_ok    = i_right.valid && !i_right.used;
            n_scan.n_pay   = i_right.pay;
            n_h_idx        = IDX_W'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= (IDX == 0) ? RST_ENTRY : '0;
            r_scan  <= '0;
        end else begin
            r_entry <= n_entry;
            r_scan  <= n_scan;
        end
        r_b_idx <= n_b_idx;
        r_h_idx <= n_h_idx;
    end

    assign o_entry = r_entry;
    assign o_scan  = r_scan;
    assign o_b_idx = r_b_idx;
    assign o_h_idx = r_h_idx;

endmodule

// File: rtl/core/bfha_ctrl.sv
// Request sequencer: decodes items, waits out the scan, issues table edits, holds the result.
module bfha_ctrl #(
    parameter int MAX_BLOCKS = bfha_pkg::MAX_BLOCKS_DEF,
    parameter int BLOCK_HDR  = bfha_pkg::BLOCK_HDR_DEF,
    parameter int POOL_HDR   = bfha_pkg::POOL_HDR_DEF,
    parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_req_size,
    input  logic [15:0]        i_offset,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [15:0]        o_result_offset,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_data,
    output bfha_pkg::t_cmd     o_cmd,
    output logic [IDX_W-1:0]   o_cmd_idx,
    output bfha_pkg::t_query   o_query,
    input  bfha_pkg::t_scan    i_scan,
    input  logic [IDX_W-1:0]   i_b_idx,
    input  logic [IDX_W-1:0]   i_h_idx
);
    import bfha_pkg::*;

    localparam int          CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int          WAIT_W = $clog2(MAX_BLOCKS + 2);
    localparam logic [WAIT_W-1:0] WAIT_N = WAIT_W'(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [16:0] HDR    = 17'(BLOCK_HDR);
    localparam logic [16:0] HDRS   = 17'(POOL_HDR + BLOCK_HDR);
    localparam logic [16:0] FLOOR  = 17'((SPLIT_MIN > BLOCK_HDR) ? SPLIT_MIN : BLOCK_HDR);
    localparam logic [16:0] ALIGN_M = 17'(SIZE_ALIGN - 1);
    localparam logic [16:0] P_MIN  = 17'(POOL_MIN);
    localparam logic [16:0] P_MAX  = 17'(POOL_MAX);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_EDIT2 = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_ALLOC  = 2'd1,
        OP_FREE   = 2'd2,
        OP_RESIZE = 2'd3
    } t_op;

    t_state            r_state, n_state;
    t_op               r_op, n_op, dec_op;
    logic [16:0]       r_size, n_size;
    logic [15:0]       r_req, n_req, r_off, n_off;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_k, n_k;
    t_entry            r_a, n_a;
    logic              r_e2_split, n_e2_split;
    logic [1:0]        r_st, n_st;
    logic [15:0]       r_res, n_res;
    logic              r_ovalid, n_ovalid;
    logic [1:0]        r_ostatus, n_ostatus;
    logic [15:0]       r_ores, n_ores;

    logic [16:0] rest_b, rest_a, sum_pn, sum_pp, sum_all, pool_v, init_pay;

    assign rest_b  = i_scan.b_pay - r_size;
    assign rest_a  = r_a.pay - r_size;
    assign sum_pn  = i_scan.h_pay + i_scan.n_pay + HDR;
    assign sum_pp  = i_scan.p_pay + i_scan.h_pay + HDR;
    assign sum_all = sum_pp + i_scan.n_pay + HDR;
    assign pool_v  = (i_cfg_data < P_MIN) ? P_MIN : ((i_cfg_data > P_MAX) ? P_MAX : i_cfg_data);
    assign init_pay = (pool_v > HDRS) ? (pool_v - HDRS) : 17'd0;

    always_comb begin
        unique case (i_func)
            FUNC_ALLOC:  dec_op = OP_ALLOC;
            FUNC_FREE:   dec_op = (i_offset == 16'd0) ? OP_NONE : OP_FREE;
            FUNC_RESIZE: dec_op = (i_offset == 16'd0) ? OP_ALLOC : OP_RESIZE;
            default:     dec_op = OP_NONE;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_size     = r_size;
        n_req      = r_req;
        n_off      = r_off;
        n_wait     = r_wait;
        n_count    = r_count;
        n_k        = r_k;
        n_a        = r_a;
        n_e2_split = r_e2_split;
        n_st       = r_st;
        n_res      = r_res;
        n_ovalid   = r_ovalid;
        n_ostatus  = r_ostatus;
        n_ores     = r_ores;
        o_cmd      = '0;
        o_cmd_idx  = '0;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        if (i_cfg_we) begin
            o_cmd.op   = CMD_INIT;
            o_cmd.a    = '{valid: 1'b1, used: 1'b0, start: 16'(POOL_HDR), pay: init_pay};
            n_count    = CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = dec_op;
                    n_req  = i_req_size;
                    n_off  = i_offset;
                    n_size = ({1'b0, i_req_size} + ALIGN_M) & ~ALIGN_M;
                    n_wait = WAIT_N;
                    n_st   = ST_OK;
                    n_res  = '0;
                    n_state = (dec_op == OP_NONE) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_wait == '0) n_state = S_EXEC;
                else              n_wait  = r_wait - 1'b1;
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_ALLOC: begin
                        if (!i_scan.b_found) begin
                            n_st = ST_NOFIT;
                        end else begin
                            o_cmd_idx = i_b_idx;
                            n_res = 16'({1'b0, i_scan.b_start} + HDR);
                            if (rest_b >= FLOOR && r_count < CNT_MAX) begin
                                o_cmd.op = CMD_SPLIT;
                                o_cmd.a  = '{valid: 1'b1, used: 1'b1,
                                             start: i_scan.b_start, pay: r_size};
                                o_cmd.b  = '{valid: 1'b1, used: 1'b0,
                                             start: 16'({1'b0, i_scan.b_start} + HDR + r_size),
                                             pay: rest_b - HDR};
                                n_count  = r_count + 1'b1;
                            end else begin
                                o_cmd.op = CMD_WR;
                                o_cmd.a  = '{valid: 1'b1, used: 1'b1,
                                             start: i_scan.b_start, pay: i_scan.b_pay};
                            end
                        end
                    end
                    OP_FREE, OP_RESIZE: begin
                        if (!i_scan.h_found || !i_scan.h_used) begin
                            n_st = ST_BADOFF;
                        end else if (r_op == OP_FREE || r_req == 16'd0) begin
                            // free, merging with free neighbors
                            if (i_scan.p_ok && i_scan.n_ok) begin
                                o_cmd.op   = CMD_MERGE;
                                o_cmd_idx  = i_h_idx - 1'b1;
                                o_cmd.a    = '{valid: 1'b1, used: 1'b0,
                                               start: i_scan.p_start, pay: sum_all};
                                n_count    = r_count - 1'b1;
                                n_k        = i_h_idx - 1'b1;
                                n_a        = o_cmd.a;
                                n_e2_split = 1'b0;
                                n_state    = S_EDIT2;
                            end else begin
                                if (i_scan.p_ok) begin
                                    o_cmd.op  = CMD_MERGE;
                                    o_cmd_idx = i_h_idx - 1'b1;
                                    o_cmd.a   = '{valid: 1'b1, used: 1'b0,
                                                  start: i_scan.p_start, pay: sum_pp};
                                    n_count   = r_count - 1'b1;
                                end else if (i_scan.n_ok) begin
                                    o_cmd.op  = CMD_MERGE;
                                    o_cmd_idx = i_h_idx;
                                    o_cmd.a   = '{valid: 1'b1, used: 1'b0,
                                                  start: i_scan.h_start, pay: sum_pn};
                                    n_count   = r_count - 1'b1;
                                end else begin
                                    o_cmd.op  = CMD_WR;
                                    o_cmd_idx = i_h_idx;
                                    o_cmd.a   = '{valid: 1'b1, used: 1'b0,
                                                  start: i_scan.h_start, pay: i_scan.h_pay};
                                end
                                if (r_op == OP_RESIZE) begin
                                    // resize to zero: rescan as a zero-byte allocate
                                    n_op    = OP_ALLOC;
                                    n_size  = '0;
                                    n_wait  = WAIT_N;
                                    n_state = S_SCAN;
                                end
                            end
                        end else if (i_scan.h_pay >= {1'b0, r_req}) begin
                            n_res = r_off;
                        end else if (i_scan.n_ok && sum_pn >= r_size) begin
                            o_cmd.op   = CMD_MERGE;
                            o_cmd_idx  = i_h_idx;
                            o_cmd.a    = '{valid: 1'b1, used: 1'b1,
                                           start: i_scan.h_start, pay: sum_pn};
                            n_count    = r_count - 1'b1;
                            n_k        = i_h_idx;
                            n_a        = o_cmd.a;
                            n_e2_split = 1'b1;
                            n_res      = r_off;
                            n_state    = S_EDIT2;
                        end else begin
                            n_st = ST_NOFIT;
                        end
                    end
                    default: ;
                endcase
            end
            S_EDIT2: begin
                n_state   = S_DONE;
                o_cmd_idx = r_k;
                if (r_e2_split) begin
                    if (rest_a >= FLOOR && r_count < CNT_MAX) begin
                        o_cmd.op = CMD_SPLIT;
                        o_cmd.a  = '{valid: 1'b1, used: 1'b1, start: r_a.start, pay: r_size};
                        o_cmd.b  = '{valid: 1'b1, used: 1'b0,
                                     start: 16'({1'b0, r_a.start} + HDR + r_size),
                                     pay: rest_a - HDR};
                        n_count  = r_count + 1'b1;
                    end
                end else begin
                    // second merge of a free between two free blocks
                    o_cmd.op = CMD_MERGE;
                    o_cmd.a  = r_a;
                    n_count  = r_count - 1'b1;
                    if (r_op == OP_RESIZE) begin
                        n_op    = OP_ALLOC;
                        n_size  = '0;
                        n_wait  = WAIT_N;
                        n_state = S_SCAN;
                    end
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_st;
                    n_ores    = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_NONE;
            r_wait   <= '0;
            r_count  <= CNT_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_wait   <= n_wait;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_size     <= n_size;
        r_req      <= n_req;
        r_off      <= n_off;
        r_k        <= n_k;
        r_a        <= n_a;
        r_e2_split <= n_e2_split;
        r_st       <= n_st;
        r_res      <= n_res;
        r_ostatus  <= n_ostatus;
        r_ores     <= n_ores;
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_result_offset = r_ores;
    assign o_query         = '{size: r_size, offset: r_off};

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the best-fit heap allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bfha_pkg::*;

    // Small table so full-table behavior is reachable in a short run
    localparam int NB        = 32;
    localparam int BHDR      = BLOCK_HDR_DEF;
    localparam int PHDR      = POOL_HDR_DEF;
    localparam int SPLIT_FLR = (SPLIT_MIN > BHDR) ? SPLIT_MIN : BHDR;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int IDLE_LIMIT = 4000;

    typedef enum logic {ROW_OP, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  func;
        logic [16:0] arg;
        logic [15:0] off;
        bit          chk;
        logic [1:0]  st;
        logic [15:0] ro;
    } t_row;

    typedef struct {
        logic [1:0]  st;
        logic [15:0] ro;
    } t_resp;

    localparam int NDIR = 23;
    t_row dir_tab [NDIR] = '{
        '{ROW_OP,  FUNC_ALLOC,  17'd0,     16'd0,     1, ST_OK,     16'd20},
        '{ROW_OP,  FUNC_FREE,   17'd0,     16'd20,    1, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_FREE,   17'd0,     16'd0,     1, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_FREE,   17'd0,     16'd1234,  1, ST_BADOFF, 16'd0},
        '{ROW_OP,  FUNC_RESIZE, 17'd5,     16'd0,     1, ST_OK,     16'd20},
        '{ROW_OP,  FUNC_RESIZE, 17'd3,     16'd20,    1, ST_OK,     16'd20},
        '{ROW_OP,  FUNC_RESIZE, 17'd100,   16'd20,    0, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_RESIZE, 17'd0,     16'd20,    0, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_NONE,   17'd65535, 16'd65535, 1, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_RESIZE, 17'd4,     16'd999,   1, ST_BADOFF, 16'd0},
        '{ROW_OP,  FUNC_ALLOC,  17'd65535, 16'd0,     1, ST_NOFIT,  16'd0},
        '{ROW_CFG, FUNC_ALLOC,  17'd0,     16'd0,     0, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_ALLOC,  17'd44,    16'd0,     1, ST_OK,     16'd20},
        '{ROW_OP,  FUNC_ALLOC,  17'd0,     16'd0,     1, ST_NOFIT,  16'd0},
        '{ROW_CFG, FUNC_ALLOC,  17'h1FFFF, 16'd0,     0, ST_OK,     16'd0},
        // leaves a zero-size free block whose payload offset is past 0xFFFF
        '{ROW_OP,  FUNC_ALLOC,  17'd65500, 16'd0,     1, ST_OK,     16'd20},
        '{ROW_OP,  FUNC_ALLOC,  17'd0,     16'd0,     1, ST_NOFIT,  16'd0},
        '{ROW_OP,  FUNC_FREE,   17'd0,     16'd20,    1, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_ALLOC,  17'd16,    16'd0,     0, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_ALLOC,  17'd16,    16'd0,     0, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_RESIZE, 17'd64,    16'd20,    0, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_FREE,   17'd0,     16'd56,    0, ST_OK,     16'd0},
        '{ROW_OP,  FUNC_RESIZE, 17'd64,    16'd20,    0, ST_OK,     16'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [15:0] i_req_size = '0;
    logic [15:0] i_offset = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_result_offset;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    best_fit_heap_allocator_top #(.MAX_BLOCKS(NB)) DUT (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func, .i_req_size, .i_offset,
        .o_valid, .i_ready, .o_status, .o_result_offset, .i_cfg_we, .i_cfg_data
    );

    // Shadow block table
    int unsigned blk_start [NB];
    int unsigned blk_pay   [NB];
    bit          blk_used  [NB];
    int unsigned blk_cnt;
    int unsigned pool_sz;

    t_resp pending_q [$];
    int    errs;
    int    got;
    bit    quiet;
    int    hold;
    int    idle_cyc;

    function automatic void table_init();
        for (int j = 0; j < NB; j++) begin
            blk_start[j] = 0;
            blk_pay[j] = 0;
            blk_used[j] = 0;
        end
        blk_start[0] = PHDR;
        blk_pay[0] = (pool_sz > PHDR + BHDR) ? pool_sz - PHDR - BHDR : 0;
        blk_cnt = 1;
    endfunction

    function automatic void drop_entry(int i);
        for (int j = i; j < int'(blk_cnt) - 1; j++) begin
            blk_start[j] = blk_start[j+1];
            blk_pay[j] = blk_pay[j+1];
            blk_used[j] = blk_used[j+1];
        end
        blk_cnt--;
    endfunction

    function automatic void try_split(int i, int unsigned sz);
        int unsigned rest;
        rest = blk_pay[i] - sz;
        if (rest < SPLIT_FLR || blk_cnt >= NB) return;
        for (int j = int'(blk_cnt) - 1; j > i; j--) begin
            blk_start[j+1] = blk_start[j];
            blk_pay[j+1] = blk_pay[j];
            blk_used[j+1] = blk_used[j];
        end
        blk_start[i+1] = blk_start[i] + BHDR + sz;
        blk_pay[i+1] = rest - BHDR;
        blk_used[i+1] = 0;
        blk_pay[i] = sz;
        blk_cnt++;
    endfunction

    function automatic int unsigned round4(int unsigned x);
        return (x + SIZE_ALIGN - 1) / SIZE_ALIGN * SIZE_ALIGN;
    endfunction

    function automatic logic [1:0] take_best(int unsigned req, output int unsigned res);
        int unsigned sz;
        int best;
        sz = round4(req);
        best = -1;
        res = 0;
        for (int i = 0; i < int'(blk_cnt); i++) begin
            if (blk_used[i] || blk_pay[i] < sz) continue;
            if (blk_start[i] + BHDR > ADDR_MAX) continue;
            if (best < 0 || blk_pay[i] < blk_pay[best]) best = i;
        end
        if (best < 0) return ST_NOFIT;
        try_split(best, sz);
        blk_used[best] = 1;
        res = blk_start[best] + BHDR;
        return ST_OK;
    endfunction

    function automatic int find_live(int unsigned off);
        for (int i = 0; i < int'(blk_cnt); i++)
            if (blk_start[i] + BHDR == off) return blk_used[i] ? i : -1;
        return -1;
    endfunction

    function automatic void release_entry(int i);
        blk_used[i] = 0;
        if (i > 0 && !blk_used[i-1]) begin
            blk_pay[i-1] += blk_pay[i] + BHDR;
            drop_entry(i);
            i--;
        end
        if (i + 1 < int'(blk_cnt) && !blk_used[i+1]) begin
            blk_pay[i] += blk_pay[i+1] + BHDR;
            drop_entry(i + 1);
        end
    endfunction

    function automatic t_resp predict_alloc(logic [1:0] fn, int unsigned req, int unsigned off);
        t_resp r;
        int unsigned res;
        int idx;
        int unsigned sz;
        res = 0;
        r.st = ST_OK;
        case (fn)
            FUNC_ALLOC: r.st = take_best(req, res);
            FUNC_FREE: begin
                if (off != 0) begin
                    idx = find_live(off);
                    if (idx < 0) r.st = ST_BADOFF;
                    else release_entry(idx);
                end
            end
            FUNC_RESIZE: begin
                idx = (off == 0) ? -1 : find_live(off);
                if (off == 0) begin
                    r.st = take_best(req, res);
                end else if (idx < 0) begin
                    r.st = ST_BADOFF;
                end else if (req == 0) begin
                    release_entry(idx);
                    r.st = take_best(0, res);
                end else if (blk_pay[idx] >= req) begin
                    res = off;
                end else begin
                    sz = round4(req);
                    if (idx + 1 < int'(blk_cnt) && !blk_used[idx+1] &&
                        blk_pay[idx] + blk_pay[idx+1] + BHDR >= sz) begin
                        blk_pay[idx] += blk_pay[idx+1] + BHDR;
                        drop_entry(idx + 1);
                        try_split(idx, sz);
                        res = off;
                    end else begin
                        r.st = ST_NOFIT;
                    end
                end
            end
            default: ;
        endcase
        r.ro = res[15:0];
        return r;
    endfunction

    // Payload offset of a random in-use block, 0 if none
    function automatic int unsigned pick_live();
        int n;
        int k;
        n = 0;
        for (int i = 0; i < int'(blk_cnt); i++) if (blk_used[i]) n++;
        if (n == 0) return 0;
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < int'(blk_cnt); i++) begin
            if (blk_used[i]) begin
                if (k == 0) return blk_start[i] + BHDR;
                k--;
            end
        end
        return 0;
    endfunction

    task automatic send_item(logic [1:0] fn, logic [15:0] req, logic [15:0] off,
                             bit chk, t_resp typed);
        t_resp r;
        i_valid <= 1'b1;
        i_func <= fn;
        i_req_size <= req;
        i_offset <= off;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        r = predict_alloc(fn, 32'(req), 32'(off));
        pending_q.push_back(chk ? typed : r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic write_pool(logic [16:0] v);
        int unsigned c;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        c = 32'(v);
        pool_sz = (c < POOL_MIN) ? POOL_MIN : (c > POOL_MAX) ? POOL_MAX : c;
        table_init();
    endtask

    // Result side: random stalls, one long hold-off, checking
    always @(posedge i_clk) begin
        t_resp e;
        if (o_valid && i_ready) begin
            got <= got + 1;
            if (pending_q.size() == 0) begin
                errs++;
                if (errs <= 10) $display("unexpected item st=%0d ro=%0d", o_status,
                                         o_result_offset);
            end else begin
                e = pending_q.pop_front();
                if (e.st !== o_status || e.ro !== o_result_offset) begin
                    errs++;
                    if (errs <= 10)
                        $display("mismatch: exp st=%0d ro=%0d, got st=%0d ro=%0d",
                                 e.st, e.ro, o_status, o_result_offset);
                end
            end
        end
        if (o_valid && i_ready && got == 60) begin
            hold <= 300;
            i_ready <= 1'b0;
        end else if (hold > 0) begin
            hold <= hold - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            hold <= $urandom_range(0, 7);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [16:0] pools [6];
        t_resp none;
        int unsigned sz;
        int unsigned off;
        int r;
        errs = 0;
        got = 0;
        quiet = 0;
        hold = 0;
        idle_cyc = 0;
        none = '{ST_OK, 16'd0};
        pools = '{17'd4096, 17'd256, 17'd65536, 17'd64, 17'd1024, 17'd0};
        pool_sz = POOL_MAX;
        table_init();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[n]) begin
            if (dir_tab[n].kind == ROW_CFG)
                write_pool(dir_tab[n].arg);
            else
                send_item(dir_tab[n].func, dir_tab[n].arg[15:0], dir_tab[n].off,
                          dir_tab[n].chk, '{dir_tab[n].st, dir_tab[n].ro});
        end

        pools[5] = 17'($urandom_range(0, 17'h1FFFF));
        for (int ph = 0; ph < 6; ph++) begin
            write_pool(pools[ph]);
            quiet = (ph == 5);
            for (int k = 0; k < 45; k++) begin
                r = $urandom_range(0, 99);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: sz = $urandom_range(0, 120);
                    12, 13, 14, 15, 16: sz = $urandom_range(0, 2000);
                    17, 18: sz = $urandom_range(0, 20000);
                    default: sz = $urandom_range(0, 16'hFFFF);
                endcase
                off = pick_live();
                if (r < 45 || (off == 0 && r < 85))
                    send_item(FUNC_ALLOC, 16'(sz), 16'($urandom_range(0, 16'hFFFF)), 0,
                              none);
                else if (r < 70)
                    send_item(FUNC_FREE, 16'(sz), 16'(off), 0, none);
                else if (r < 85)
                    send_item(FUNC_RESIZE, ($urandom_range(0, 4) == 0) ? 16'd0 : 16'(sz),
                              16'(off), 0, none);
                else if (r < 95)
                    send_item(2'($urandom_range(FUNC_FREE, FUNC_RESIZE)), 16'(sz),
                              16'($urandom_range(0, 16'hFFFF)), 0, none);
                else
                    send_item(FUNC_NONE, 16'(sz), 16'($urandom_range(0, 16'hFFFF)), 0,
                              none);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errs == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/bfha_pkg.sv
rtl/core/bfha_cell.sv
rtl/core/bfha_ctrl.sv
rtl/core/best_fit_heap_allocator_top.sv
bench/testbench.sv
